// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define HPMB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HPMB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/hpmb_pkg.sv -----
// types and constants of the homography point mapper
// no dependencies
package hpmb_pkg;

    localparam int COEFS     = 9;
    localparam int CAM_ID_W  = 4;
    localparam int CIDX_W    = 4;
    localparam int COEF_W    = 32;
    localparam int PIX_W     = 24;
    localparam int ID_W      = 16;
    localparam int CONF_W    = 16;
    localparam int TS_W      = 63;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = 56;
    localparam int ACC_W     = 58;
    localparam int Q_W       = 32;
    localparam int NZP_W     = 49;
    localparam int NZQ_W     = 33;
    localparam int MAG_W     = 34;
    localparam int DIV_STEPS = 32;
    localparam int Q_DEPTH   = 4;

    localparam logic [CIDX_W-1:0] LAST_COEF = 4'd8;
    localparam logic [ACC_W-1:0] W_NEAR_ZERO = 58'd42;
    localparam logic [ACC_W-1:0] INF_MAG_LIMIT = 58'd268435456;
    localparam logic [19:0] INF_SCALE = 20'd1000000;
    localparam logic [MAG_W-1:0] MAG_SAT = 34'h080000000;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;

    localparam logic signed [31:0] X_MIN_RST = 32'sd0;
    localparam logic signed [31:0] X_MAX_RST = 32'sd6553600;
    localparam logic signed [31:0] Y_MIN_RST = 32'sd0;
    localparam logic signed [31:0] Y_MAX_RST = 32'sd393216;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_XFORM = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN = 4'd0,
        CFG_X_MAX = 4'd1,
        CFG_Y_MIN = 4'd2,
        CFG_Y_MAX = 4'd3
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [ID_W-1:0]     ball_id;
        logic [CAM_ID_W-1:0] camera_id;
        logic [CONF_W-1:0]   confidence;
        logic [TS_W-1:0]     time_stamp;
    } t_tag;

    typedef struct packed {
        t_coef [COEFS-1:0]        h;
        logic signed [PIX_W-1:0]  px;
        logic signed [PIX_W-1:0]  py;
        t_tag                     tag;
    } t_job;

endpackage

// ----- hdl/hpmb_if.sv -----
// channel interfaces: point items in, mapped items out, register writes
// depends on hpmb_pkg
interface hpmb_in_if;
    import hpmb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [CAM_ID_W-1:0]     camera_id;
    logic [CIDX_W-1:0]       coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [CONF_W-1:0]       confidence;
    logic [ID_W-1:0]         ball_id;
    logic [TS_W-1:0]         time_stamp;
    modport source (output valid, mode, camera_id, coef_index, coef_value, pixel_x,
                    pixel_y, confidence, ball_id, time_stamp, input ready);
    modport sink (input valid, mode, camera_id, coef_index, coef_value, pixel_x,
                  pixel_y, confidence, ball_id, time_stamp, output ready);
endinterface

interface hpmb_out_if;
    import hpmb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      ball_id_res;
    logic [CAM_ID_W-1:0]  camera_id_res;
    logic signed [31:0]   global_x;
    logic signed [31:0]   global_y;
    logic [CONF_W-1:0]    confidence_res;
    logic [TS_W-1:0]      time_stamp_res;
    modport source (output valid, ball_id_res, camera_id_res, global_x, global_y,
                    confidence_res, time_stamp_res, input ready);
    modport sink (input valid, ball_id_res, camera_id_res, global_x, global_y,
                  confidence_res, time_stamp_res, output ready);
endinterface

interface hpmb_cfg_if;
    import hpmb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic signed [31:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/hpmb_front.sv -----
// front end: accepts items, holds coefficient tables and camera valid bits,
// forwards transform jobs of valid cameras; depends on hpmb_pkg, hpmb_if
module hpmb_front #(
    parameter int CAMERAS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hpmb_in_if.sink         i_pt,
    input  logic            i_full,
    output logic            o_push,
    output hpmb_pkg::t_job  o_job
);
    import hpmb_pkg::*;

    localparam int CAM_W = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
    localparam logic [CAM_ID_W:0] CAM_LIM = (CAM_ID_W + 1)'(CAMERAS);

    logic               accept;
    logic               cam_ok;
    logic [CAM_W-1:0]   cam_a;
    logic               is_load;
    logic               r_f_valid;
    logic [CAMERAS-1:0] r_cam_valid;
    t_coef [COEFS-1:0]  r_rd;
    logic signed [PIX_W-1:0] r_px;
    logic signed [PIX_W-1:0] r_py;
    t_tag               r_tag;

    // handshake and classification
    assign o_push     = r_f_valid && !i_full;
    assign i_pt.ready = !r_f_valid || !i_full;
    assign accept     = i_pt.valid && i_pt.ready;
    assign cam_ok     = {1'b0, i_pt.camera_id} < CAM_LIM;
    assign cam_a      = i_pt.camera_id[CAM_W-1:0];
    assign is_load    = (i_pt.mode == MODE_LOAD);

    // one table per matrix position, read for every accepted item
    for (genvar k = 0; k < COEFS; k++) begin : g_tab
        logic [COEF_W-1:0] r_mem [CAMERAS];
        always_ff @(posedge i_clk) begin
            if (accept && is_load && cam_ok && (i_pt.coef_index == CIDX_W'(k))) begin
                r_mem[cam_a] <= i_pt.coef_value;
            end
            if (accept) begin
                r_rd[k] <= r_mem[cam_a];
            end
        end
    end

    // camera valid bits and front stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_valid <= '0;
            r_f_valid   <= 1'b0;
        end else begin
            if (accept && is_load && cam_ok && (i_pt.coef_index == LAST_COEF)) begin
                r_cam_valid[cam_a] <= 1'b1;
            end
            if (accept) begin
                r_f_valid <= !is_load && cam_ok && r_cam_valid[cam_a];
            end else if (o_push) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    // point and pass-through fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px             <= i_pt.pixel_x;
            r_py             <= i_pt.pixel_y;
            r_tag.ball_id    <= i_pt.ball_id;
            r_tag.camera_id  <= i_pt.camera_id;
            r_tag.confidence <= i_pt.confidence;
            r_tag.time_stamp <= i_pt.time_stamp;
        end
    end

    assign o_job.h   = r_rd;
    assign o_job.px  = r_px;
    assign o_job.py  = r_py;
    assign o_job.tag = r_tag;

endmodule

// ----- hdl/hpmb_queue.sv -----
// short job queue between front end and arithmetic back end
// depends on hpmb_pkg
module hpmb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hpmb_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output hpmb_pkg::t_job  o_job
);
    import hpmb_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_job               r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (PTR_W + 1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_q[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/hpmb_back.sv -----
// back end: matrix products, sums, pipelined divider, saturation, bounds gate,
// output register and bound registers; depends on hpmb_pkg, hpmb_if
module hpmb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hpmb_pkg::t_job  i_job,
    output logic            o_pop,
    hpmb_cfg_if.sink        i_cfg,
    hpmb_out_if.source      o_res
);
    import hpmb_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [Q_W-1:0]   lo;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        t_tag                        tag;
        logic [ACC_W-1:0]            aw;
        t_lane [1:0]                 ln;
        logic [1:0]                  neg_n;
        logic                        neg_w;
        logic                        nz;
        logic [1:0]                  sat;
        logic [1:0]                  big;
        logic [1:0][NZQ_W-1:0]       nzq;
    } t_dst;

    // one restoring step: shift in one dividend bit, subtract if it fits
    function automatic t_lane div_step(t_lane a, logic [ACC_W-1:0] d);
        logic [ACC_W:0] t;
        logic [ACC_W:0] diff;
        t_lane          b;
        t    = {a.rem, a.lo[Q_W-1]};
        diff = t - {1'b0, d};
        b.lo = {a.lo[Q_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            b.rem = diff[ACC_W-1:0];
            b.q   = {a.q[Q_W-2:0], 1'b1};
        end else begin
            b.rem = t[ACC_W-1:0];
            b.q   = {a.q[Q_W-2:0], 1'b0};
        end
        return b;
    endfunction

    logic en;
    logic r_out_valid;

    logic signed [31:0] r_x_min, r_x_max, r_y_min, r_y_max;

    logic                     r_s1_v, r_s2_v, r_s3_v;
    logic signed [PROD_W-1:0] r_p [COEFS];
    logic signed [ACC_W-1:0]  r_acc [3];
    logic [ACC_W-1:0]         r_mag [3];
    logic [2:0]               r_neg;
    t_tag                     r_s1_tag, r_s2_tag, r_s3_tag;

    logic [DIV_STEPS:0]       r_dv;
    t_dst                     r_d [DIV_STEPS+1];
    t_dst                     n_d0;
    logic [NZP_W-1:0]         nz_prod [2];

    t_dst                     fin;
    logic [MAG_W-1:0]         f_mag [2];
    logic [1:0]               f_neg;
    logic signed [31:0]       f_g [2];
    logic                     f_in;

    // whole back end advances unless a result waits
    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en && i_valid;

    // bound registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= X_MIN_RST;
            r_x_max <= X_MAX_RST;
            r_y_min <= Y_MIN_RST;
            r_y_max <= Y_MAX_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_X_MIN: r_x_min <= i_cfg.data;
                CFG_X_MAX: r_x_max <= i_cfg.data;
                CFG_Y_MIN: r_y_min <= i_cfg.data;
                CFG_Y_MAX: r_y_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_dv   <= '0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_dv   <= {r_dv[DIV_STEPS-1:0], r_s3_v};
        end
    end

    // products, row sums, magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_p[3*r]     <= $signed(i_job.h[3*r]) * i_job.px;
                r_p[3*r + 1] <= $signed(i_job.h[3*r + 1]) * i_job.py;
                r_p[3*r + 2] <= PROD_W'($signed(i_job.h[3*r + 2])) <<< 16;
                r_acc[r] <= ACC_W'(r_p[3*r]) + ACC_W'(r_p[3*r + 1])
                            + ACC_W'(r_p[3*r + 2]);
                r_neg[r] <= r_acc[r][ACC_W-1];
                r_mag[r] <= r_acc[r][ACC_W-1] ? ACC_W'(-r_acc[r]) : ACC_W'(r_acc[r]);
            end
            r_s1_tag <= i_job.tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
        end
    end

    // classify w, near-zero scaling and divider start
    always_comb begin
        n_d0       = '0;
        n_d0.tag   = r_s3_tag;
        n_d0.aw    = r_mag[2];
        n_d0.neg_n = r_neg[1:0];
        n_d0.neg_w = r_neg[2];
        n_d0.nz    = (r_mag[2] <= W_NEAR_ZERO);
        for (int i = 0; i < 2; i++) begin
            nz_prod[i]     = NZP_W'(r_mag[i][28:0]) * NZP_W'(INF_SCALE);
            n_d0.nzq[i]    = nz_prod[i][NZP_W-1:16];
            n_d0.big[i]    = (r_mag[i] > INF_MAG_LIMIT);
            n_d0.sat[i]    = ((r_mag[i] >> 15) >= r_mag[2]);
            n_d0.ln[i].rem = {16'd0, r_mag[i][ACC_W-1:16]};
            n_d0.ln[i].lo  = {r_mag[i][15:0], 16'd0};
            n_d0.ln[i].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_d[0] <= n_d0;
    end

    // divider, one quotient bit per stage for both coordinates
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_dst n_dk;
        always_comb begin
            n_dk       = r_d[k];
            n_dk.ln[0] = div_step(r_d[k].ln[0], r_d[k].aw);
            n_dk.ln[1] = div_step(r_d[k].ln[1], r_d[k].aw);
        end
        always_ff @(posedge i_clk) begin
            if (en) r_d[k+1] <= n_dk;
        end
    end

    // select magnitude, apply sign and saturate, gate on bounds
    assign fin = r_d[DIV_STEPS];
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (fin.nz) begin
                f_mag[i] = fin.big[i] ? MAG_SAT : {1'b0, fin.nzq[i]};
                f_neg[i] = fin.neg_n[i];
            end else begin
                f_mag[i] = fin.sat[i] ? MAG_SAT : {2'b00, fin.ln[i].q};
                f_neg[i] = fin.neg_n[i] ^ fin.neg_w;
            end
            if (f_mag[i] >= MAG_SAT) begin
                f_g[i] = f_neg[i] ? SAT_MIN : SAT_MAX;
            end else begin
                f_g[i] = f_neg[i] ? -$signed(f_mag[i][31:0]) : $signed(f_mag[i][31:0]);
            end
        end
        f_in = (f_g[0] >= r_x_min) && (f_g[0] <= r_x_max)
               && (f_g[1] >= r_y_min) && (f_g[1] <= r_y_max);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[DIV_STEPS] && f_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.ball_id_res    <= fin.tag.ball_id;
            o_res.camera_id_res  <= fin.tag.camera_id;
            o_res.global_x       <= f_g[0];
            o_res.global_y       <= f_g[1];
            o_res.confidence_res <= fin.tag.confidence;
            o_res.time_stamp_res <= fin.tag.time_stamp;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

// ----- hdl/homography_point_map_bounds_top.sv -----
// channel     | dir | handshake     | carries
// i_pt        | in  | valid/ready   | load or transform item
// i_cfg       | in  | valid/ready   | bound register index and data
// o_res       | out | valid/ready   | mapped point inside the bounds
// one item per cycle in steady state while results are taken; an item passes the front
// register, queue, 3x3 products, sums, magnitudes, 32-stage divider and output register
// reset clears valid bits, queue and pipeline valids and restores the bounds
// a stalled result freezes the back end; the queue lets the front keep taking
// items until it fills
module homography_point_map_bounds_top #(
    parameter int CAMERAS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hpmb_in_if.sink      i_pt,
    hpmb_cfg_if.sink     i_cfg,
    hpmb_out_if.source   o_res
);
    import hpmb_pkg::*;

    logic   push, full, q_valid, pop;
    t_job   f_job, q_job;

    // accept and classify
    hpmb_front #(.CAMERAS(CAMERAS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (full),
        .o_push  (push),
        .o_job   (f_job)
    );

    // decoupling queue
    hpmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    // arithmetic and bounds gate
    hpmb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

// ----- hdl/hpmb_checker.sv -----
// port-level checks on the result channel of the mapper, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"
module hpmb_checker #(
    parameter int CAMERAS = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_cam,
    input logic [31:0] i_gx,
    input logic [31:0] i_gy
);

    `HPMB_ASSERT(a_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid, "result dropped while stalled")
    `HPMB_ASSERT(a_stable, i_clk, i_rst_n, i_valid && !i_ready |=> $stable(i_gx) && $stable(i_gy) && $stable(i_cam), "result changed while stalled")
    `HPMB_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !i_valid, "result valid after reset")
    `HPMB_ASSERT(a_cam, i_clk, i_rst_n, i_valid |-> ({1'b0, i_cam} < 5'(CAMERAS)), "result from camera out of range")

endmodule

bind homography_point_map_bounds_top hpmb_checker #(.CAMERAS(CAMERAS)) u_hpmb_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_cam   (o_res.camera_id_res),
    .i_gx    (o_res.global_x),
    .i_gy    (o_res.global_y)
);

// ----- bench/homography_point_map_bounds_top_tb.sv -----
// testbench for the homography point mapper with track-bounds gate
// predicts each mapped point, checks results in order under random idling and stalling
// depends on hpmb_pkg, hpmb_if and homography_point_map_bounds_top
module homography_point_map_bounds_top_tb;
    import hpmb_pkg::*;

    localparam int NCAM = 8;
    localparam int LATENCY = 39;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                    mode;
        logic [CAM_ID_W-1:0]     camera_id;
        logic [CIDX_W-1:0]       coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic [CONF_W-1:0]       confidence;
        logic [ID_W-1:0]         ball_id;
        logic [TS_W-1:0]         time_stamp;
    } t_point_item;

    typedef struct packed {
        logic [ID_W-1:0]     ball_id;
        logic [CAM_ID_W-1:0] camera_id;
        logic signed [31:0]  gx;
        logic signed [31:0]  gy;
        logic [CONF_W-1:0]   confidence;
        logic [TS_W-1:0]     time_stamp;
    } t_mapped;

    logic i_clk;
    logic i_rst_n;

    hpmb_in_if  pt_ch();
    hpmb_cfg_if cfg_ch();
    hpmb_out_if res_ch();

    homography_point_map_bounds_top #(.CAMERAS(NCAM)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pt(pt_ch.sink), .i_cfg(cfg_ch.sink), .o_res(res_ch.source)
    );

    // predictor state
    t_coef             h_tab [NCAM][COEFS];
    logic              cam_ok [NCAM];
    logic signed [31:0] bx_lo, bx_hi, by_lo, by_hi;

    t_point_item pending_items [$];
    t_mapped     expected_points [$];
    int          idle_pct, stall_pct;
    int          mismatches;
    int          unexpected;
    longint      cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // saturate a magnitude with sign into signed 32 bits
    function automatic logic signed [31:0] sat_signed(logic [63:0] mag, logic neg);
        if (mag > 64'h80000000) mag = 64'h80000000;
        if (neg) return 32'(-$signed({1'b0, mag[31:0]}));
        if (mag >= 64'h80000000) return 32'sh7fffffff;
        return mag[31:0];
    endfunction

    // divide numerator by w into Q16.16, with near-zero w handling
    function automatic logic signed [31:0] divide_by_w(longint num, longint w);
        logic [63:0] an, aw, q;
        an = (num < 0) ? -num : num;
        aw = (w < 0) ? -w : w;
        if (aw <= 42) begin
            if (an > 64'd268435456) q = 64'h80000000;
            else q = (an * 64'd1000000) >> 16;
            return sat_signed(q, num < 0);
        end
        if ((an >> 15) >= aw) q = 64'h80000000;
        else q = 64'((128'(an) << 16) / 128'(aw));
        return sat_signed(q, (num < 0) != (w < 0));
    endfunction

    // apply one accepted item to the predictor
    task automatic map_point(t_point_item it);
        longint px, py, nx, ny, w;
        int c;
        t_mapped m;
        c = it.camera_id;
        if (it.mode == MODE_LOAD) begin
            if (c < NCAM && it.coef_index < COEFS) begin
                h_tab[c][it.coef_index] = it.coef_value;
                if (it.coef_index == LAST_COEF) cam_ok[c] = 1'b1;
            end
            return;
        end
        if (c >= NCAM || !cam_ok[c]) return;
        px = it.pixel_x;
        py = it.pixel_y;
        nx = longint'(h_tab[c][0]) * px + longint'(h_tab[c][1]) * py
             + longint'(h_tab[c][2]) * 65536;
        ny = longint'(h_tab[c][3]) * px + longint'(h_tab[c][4]) * py
             + longint'(h_tab[c][5]) * 65536;
        w  = longint'(h_tab[c][6]) * px + longint'(h_tab[c][7]) * py
             + longint'(h_tab[c][8]) * 65536;
        m.gx = divide_by_w(nx, w);
        m.gy = divide_by_w(ny, w);
        if (m.gx < bx_lo || m.gx > bx_hi || m.gy < by_lo || m.gy > by_hi) return;
        m.ball_id = it.ball_id;
        m.camera_id = it.camera_id;
        m.confidence = it.confidence;
        m.time_stamp = it.time_stamp;
        expected_points = {expected_points, m};
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_ch.valid <= 1'b0;
        end else begin
            if (pt_ch.valid && pt_ch.ready) map_point(t_point_item'({pt_ch.mode,
                pt_ch.camera_id, pt_ch.coef_index, pt_ch.coef_value, pt_ch.pixel_x,
                pt_ch.pixel_y, pt_ch.confidence, pt_ch.ball_id, pt_ch.time_stamp}));
            if (!pt_ch.valid || pt_ch.ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_point_item it;
                    it = pending_items.pop_front();
                    pt_ch.valid <= 1'b1;
                    {pt_ch.mode, pt_ch.camera_id, pt_ch.coef_index, pt_ch.coef_value,
                     pt_ch.pixel_x, pt_ch.pixel_y, pt_ch.confidence, pt_ch.ball_id,
                     pt_ch.time_stamp} <= it;
                end else begin
                    pt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_points.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("result with none expected: ball %0d cam %0d",
                                 res_ch.ball_id_res, res_ch.camera_id_res);
                end else begin
                    t_mapped e;
                    e = expected_points.pop_front();
                    if (e.ball_id !== res_ch.ball_id_res || e.camera_id !== res_ch.camera_id_res
                        || e.gx !== res_ch.global_x || e.gy !== res_ch.global_y
                        || e.confidence !== res_ch.confidence_res
                        || e.time_stamp !== res_ch.time_stamp_res) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display("mismatch exp id %0d cam %0d x %0d y %0d c %0d t %0d / got id %0d cam %0d x %0d y %0d c %0d t %0d",
                                     e.ball_id, e.camera_id, e.gx, e.gy, e.confidence,
                                     e.time_stamp, res_ch.ball_id_res, res_ch.camera_id_res,
                                     res_ch.global_x, res_ch.global_y, res_ch.confidence_res,
                                     res_ch.time_stamp_res);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one random item
    function automatic t_point_item rand_item(int load_pct, int bad_pct);
        t_point_item it;
        it.mode = ($urandom_range(99) < load_pct) ? MODE_LOAD : MODE_XFORM;
        it.camera_id = ($urandom_range(99) < bad_pct) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(NCAM - 1));
        it.coef_index = ($urandom_range(99) < bad_pct) ? 4'($urandom_range(15))
                                                       : 4'($urandom_range(8));
        case ($urandom_range(3))
            0: it.coef_value = $urandom;
            1: it.coef_value = 32'($signed(20'($urandom))) <<< $urandom_range(4);
            default: it.coef_value = 32'($signed(18'($urandom)));
        endcase
        case ($urandom_range(3))
            0: begin it.pixel_x = 24'($urandom); it.pixel_y = 24'($urandom); end
            default: begin
                it.pixel_x = 24'($signed(18'($urandom)));
                it.pixel_y = 24'($signed(18'($urandom)));
            end
        endcase
        it.confidence = 16'($urandom);
        it.ball_id = 16'($urandom);
        it.time_stamp = 63'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_point_item load_item(int cam, int idx, logic signed [31:0] v);
        t_point_item it;
        it = rand_item(100, 0);
        it.camera_id = 4'(cam);
        it.coef_index = 4'(idx);
        it.coef_value = v;
        return it;
    endfunction

    function automatic t_point_item xform_item(int cam, logic signed [23:0] x,
                                               logic signed [23:0] y);
        t_point_item it;
        it = rand_item(0, 0);
        it.camera_id = 4'(cam);
        it.pixel_x = x;
        it.pixel_y = y;
        return it;
    endfunction

    // append one item to the driver's pending list
    task automatic enqueue(t_point_item it);
        pending_items = {pending_items, it};
    endtask

    // write one bound register on the config channel, valid left high
    task automatic write_bound(t_cfg_idx idx, logic signed [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_X_MIN: bx_lo = v;
            CFG_X_MAX: bx_hi = v;
            CFG_Y_MIN: by_lo = v;
            default:   by_hi = v;
        endcase
    endtask

    task automatic set_bounds(logic signed [31:0] a, b, c, d);
        write_bound(CFG_X_MIN, a);
        write_bound(CFG_X_MAX, b);
        write_bound(CFG_Y_MIN, c);
        write_bound(CFG_Y_MAX, d);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for all results, then the pipeline depth
    task automatic drain;
        while (pending_items.size() > 0 || pt_ch.valid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // full matrix for one camera: load every coefficient with a random value
    task automatic load_camera(int cam);
        t_point_item r;
        for (int k = 0; k < COEFS; k++) begin
            r = rand_item(100, 0);
            enqueue(load_item(cam, k, r.coef_value));
        end
    endtask

    initial begin
        int seg;
        mismatches = 0;
        unexpected = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        for (int c = 0; c < NCAM; c++) begin
            cam_ok[c] = 1'b0;
            for (int k = 0; k < COEFS; k++) h_tab[c][k] = '0;
        end
        bx_lo = X_MIN_RST; bx_hi = X_MAX_RST; by_lo = Y_MIN_RST; by_hi = Y_MAX_RST;
        {pt_ch.mode, pt_ch.camera_id, pt_ch.coef_index, pt_ch.coef_value, pt_ch.pixel_x,
         pt_ch.pixel_y, pt_ch.confidence, pt_ch.ball_id, pt_ch.time_stamp} = '0;
        pt_ch.valid = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_X_MIN;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: invalid camera, ignored loads, identity and near-zero w
        enqueue(xform_item(0, 24'sd0, 24'sd0));
        enqueue(xform_item(15, 24'sd0, 24'sd0));
        enqueue(load_item(9, 8, 32'sd65536));
        enqueue(load_item(1, 12, 32'sd65536));
        enqueue(xform_item(1, 24'sd0, 24'sd0));
        for (int k = 0; k < COEFS; k++)
            enqueue(load_item(0, k, (k % 4 == 0) ? 32'sd65536 : 32'sd0));
        enqueue(xform_item(0, 24'sd65536, 24'sd131072));
        enqueue(xform_item(0, 24'sh7fffff, 24'sh7fffff));
        enqueue(xform_item(0, 24'sh800000, 24'sh800000));
        enqueue(xform_item(0, 24'sd0, 24'sd0));
        enqueue(load_item(0, 8, 32'sd0));
        enqueue(xform_item(0, 24'sd100, 24'sd100));
        enqueue(load_item(0, 2, 32'sh7fffffff));
        enqueue(xform_item(0, 24'sd0, 24'sd0));
        enqueue(load_item(0, 2, 32'sh80000000));
        enqueue(xform_item(0, 24'sd0, 24'sd0));
        drain();
        set_bounds(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        enqueue(xform_item(0, 24'sd0, 24'sd0));
        enqueue(load_item(0, 8, 32'sd65536));
        enqueue(xform_item(0, 24'sh7fffff, 24'sh800000));
        for (int c = 0; c < NCAM; c++) load_camera(c);
        drain();

        // random phases, bounds changed between them
        for (seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            case (seg)
                0: set_bounds(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
                3: set_bounds(32'sd10, 32'sd0, 32'sh80000000, 32'sh7fffffff);
                5: set_bounds(-32'sd6553600, 32'sd6553600, -32'sd6553600, 32'sd6553600);
                7: set_bounds(X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST);
                default: set_bounds($urandom_range(1) ? 32'sh80000000 : -32'sd131072 * 8,
                                    32'sd13107200, 32'sh80000000, 32'sd1966080);
            endcase
            if (seg % 2 == 1) load_camera($urandom_range(NCAM - 1));
            for (int n = 0; n < 128; n++)
                enqueue(rand_item(10, 5));
            drain();
        end

        if (mismatches == 0 && unexpected == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
